[design/eip_pkg.sv]
package eip_pkg;

    // verdict codes
    typedef enum logic [3:0] {
        ST_UDP_OK       = 4'd0,
        ST_SHORT        = 4'd1,
        ST_ARP          = 4'd2,
        ST_NOT_IPV4     = 4'd3,
        ST_BAD_IHL      = 4'd4,
        ST_BAD_TOTAL    = 4'd5,
        ST_FRAGMENT     = 4'd6,
        ST_NOT_UDP      = 4'd7,
        ST_BAD_UDP_LEN  = 4'd8
    } t_status;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] FRAG_MASK      = 16'h3FFF;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] MIN_IP_HDR_LEN = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // header fields held by the capture stage, plus the frame-end mark
    typedef struct packed {
        logic        done;
        logic [15:0] length;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [15:0] total_len;
        logic [15:0] flags_frag;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] ports;
        logic [15:0] udp_len;
    } t_capture;

    // one verdict word
    typedef struct packed {
        t_status     status;
        logic [15:0] frame_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
        logic [6:0]  payload_offset;
        logic [15:0] payload_length;
        logic        fragment_drop;
    } t_result;

endpackage

[design/eth_ipv4_udp_header_parser.sv]
// Ethernet/IPv4/UDP header parser. Frame bytes come in one word per clock,
// destination MAC first, with i_last_byte on the final byte; the block takes
// one byte every cycle for as long as the output side does not stall. Each
// frame yields exactly one verdict word; o_valid rises once its last byte has
// passed the input register, the capture stage and the result register. A
// finished frame waiting behind a stalled result holds the capture stage, and
// o_stall rises for the next byte until it moves on.
// No word comes out for the other bytes. o_status gives udp ok (0) or the
// first failed check in order: short, ARP, not IPv4, bad IHL, bad total
// length, fragment (o_fragment_drop set), not UDP, bad UDP length. Addresses,
// ports, payload offset and payload length are zero unless the status is
// udp ok. o_frame_length counts bytes and saturates at 65535. There is no setup.
module eth_ipv4_udp_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    // verdict output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [15:0] o_frame_length,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [6:0]  o_payload_offset,
    output logic [15:0] o_payload_length,
    output logic        o_fragment_drop
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    eip_pkg::t_result  r_out;
    eip_pkg::t_capture cap;
    eip_pkg::t_result  res;
    logic              out_free;
    logic              cap_ready;
    logic              cap_en;
    logic              take;

    // Result register frees up when empty or being read this cycle.
    assign out_free  = !r_out_valid || !i_stall;
    // A finished frame must leave the capture stage before the next byte
    // updates it; the header fields of the next frame would overwrite it.
    assign take      = cap.done && out_free;
    assign cap_ready = !cap.done || out_free;
    assign cap_en    = r_in_valid && cap_ready;
    // input register acts as the skid stage
    assign o_stall   = r_in_valid && !cap_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
        end
    end

    eip_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (cap_en),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_cap   (cap)
    );

    eip_verdict u_verdict (
        .i_cap (cap),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= cap.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take)
            r_out <= res;
    end

    assign o_valid               = r_out_valid;
    assign o_status              = r_out.status;
    assign o_frame_length        = r_out.frame_length;
    assign o_source_address      = r_out.src_addr;
    assign o_destination_address = r_out.dst_addr;
    assign o_source_port         = r_out.udp_sport;
    assign o_destination_port    = r_out.udp_dport;
    assign o_payload_offset      = r_out.payload_offset;
    assign o_payload_length      = r_out.payload_length;
    assign o_fragment_drop       = r_out.fragment_drop;

endmodule

[design/eip_capture.sv]
module eip_capture (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output eip_pkg::t_capture   o_cap
);

    logic [15:0] r_count;
    logic [15:0] n_count;
    logic        r_done;
    logic [15:0] r_len;
    logic [15:0] r_etype;
    logic [7:0]  r_ver_ihl;
    logic [15:0] r_total_len;
    logic [15:0] r_flags_frag;
    logic [7:0]  r_protocol;
    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [31:0] r_ports;
    logic [15:0] r_udp_len;
    logic [15:0] udp_base;

    // UDP header follows the IP header; IHL counts 32-bit words
    assign udp_base = eip_pkg::ETH_HDR_LEN + {10'd0, r_ver_ihl[3:0], 2'b00};
    assign n_count  = (r_count < eip_pkg::COUNT_MAX) ? r_count + 16'd1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_en) begin
            r_count <= i_last ? 16'd0 : n_count;
            r_done  <= i_last;
        end else if (i_take) begin
            r_done  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_last)
                r_len <= n_count;
            if (r_count == 16'd12 || r_count == 16'd13)
                r_etype <= {r_etype[7:0], i_byte};
            if (r_count == 16'd14)
                r_ver_ihl <= i_byte;
            if (r_count == 16'd16 || r_count == 16'd17)
                r_total_len <= {r_total_len[7:0], i_byte};
            if (r_count == 16'd20 || r_count == 16'd21)
                r_flags_frag <= {r_flags_frag[7:0], i_byte};
            if (r_count == 16'd23)
                r_protocol <= i_byte;
            if (r_count >= 16'd26 && r_count <= 16'd29)
                r_src_addr <= {r_src_addr[23:0], i_byte};
            if (r_count >= 16'd30 && r_count <= 16'd33)
                r_dst_addr <= {r_dst_addr[23:0], i_byte};
            // IHL is only trusted once its byte has gone by
            if (r_count > 16'd14) begin
                if (r_count >= udp_base && r_count <= udp_base + 16'd3)
                    r_ports <= {r_ports[23:0], i_byte};
                if (r_count == udp_base + 16'd4 || r_count == udp_base + 16'd5)
                    r_udp_len <= {r_udp_len[7:0], i_byte};
            end
        end
    end

    always_comb begin
        o_cap.done       = r_done;
        o_cap.length     = r_len;
        o_cap.etype      = r_etype;
        o_cap.ver_ihl    = r_ver_ihl;
        o_cap.total_len  = r_total_len;
        o_cap.flags_frag = r_flags_frag;
        o_cap.protocol   = r_protocol;
        o_cap.src_addr   = r_src_addr;
        o_cap.dst_addr   = r_dst_addr;
        o_cap.ports      = r_ports;
        o_cap.udp_len    = r_udp_len;
    end

endmodule

[design/eip_verdict.sv]
module eip_verdict (
    input  eip_pkg::t_capture   i_cap,
    output eip_pkg::t_result    o_res
);

    logic [3:0]       ihl;
    logic [15:0]      hdr_len;
    logic [16:0]      len_ext;
    logic [16:0]      ip_end;
    logic [16:0]      hdr_end;
    logic [15:0]      ip_payload;
    eip_pkg::t_status status;

    assign ihl        = i_cap.ver_ihl[3:0];
    assign hdr_len    = {10'd0, ihl, 2'b00};
    assign len_ext    = {1'b0, i_cap.length};
    assign hdr_end    = {1'b0, eip_pkg::ETH_HDR_LEN} + {1'b0, hdr_len};
    assign ip_end     = {1'b0, eip_pkg::ETH_HDR_LEN} + {1'b0, i_cap.total_len};
    assign ip_payload = i_cap.total_len - hdr_len;

    always_comb begin
        priority if (i_cap.length < eip_pkg::ETH_HDR_LEN)
            status = eip_pkg::ST_SHORT;
        else if (i_cap.etype == eip_pkg::ETHERTYPE_ARP)
            status = eip_pkg::ST_ARP;
        else if (i_cap.etype != eip_pkg::ETHERTYPE_IPV4)
            status = eip_pkg::ST_NOT_IPV4;
        else if (i_cap.length < eip_pkg::ETH_HDR_LEN + eip_pkg::MIN_IP_HDR_LEN)
            status = eip_pkg::ST_SHORT;
        else if (i_cap.ver_ihl[7:4] != eip_pkg::IP_VERSION || ihl < eip_pkg::MIN_IHL
                 || len_ext < hdr_end)
            status = eip_pkg::ST_BAD_IHL;
        else if (i_cap.total_len < hdr_len || len_ext < ip_end)
            status = eip_pkg::ST_BAD_TOTAL;
        else if ((i_cap.flags_frag & eip_pkg::FRAG_MASK) != 16'd0)
            status = eip_pkg::ST_FRAGMENT;
        else if (i_cap.protocol != eip_pkg::PROTO_UDP)
            status = eip_pkg::ST_NOT_UDP;
        else if (ip_payload < eip_pkg::UDP_HDR_LEN || i_cap.udp_len < eip_pkg::UDP_HDR_LEN
                 || ip_payload < i_cap.udp_len)
            status = eip_pkg::ST_BAD_UDP_LEN;
        else
            status = eip_pkg::ST_UDP_OK;
    end

    always_comb begin
        o_res                = '0;
        o_res.status         = status;
        o_res.frame_length   = i_cap.length;
        o_res.fragment_drop  = (status == eip_pkg::ST_FRAGMENT);
        if (status == eip_pkg::ST_UDP_OK) begin
            o_res.src_addr       = i_cap.src_addr;
            o_res.dst_addr       = i_cap.dst_addr;
            o_res.udp_sport      = i_cap.ports[31:16];
            o_res.udp_dport      = i_cap.ports[15:0];
            o_res.payload_offset = 7'd22 + {1'b0, ihl, 2'b00};
            o_res.payload_length = i_cap.udp_len - eip_pkg::UDP_HDR_LEN;
        end
    end

endmodule

[design/eip_checker.sv]
module eip_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [3:0]  o_status,
    input  logic [15:0] o_frame_length,
    input  logic [31:0] o_source_address,
    input  logic [31:0] o_destination_address,
    input  logic [15:0] o_source_port,
    input  logic [15:0] o_destination_port,
    input  logic [6:0]  o_payload_offset,
    input  logic [15:0] o_payload_length,
    input  logic        o_fragment_drop
);

    // a stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_frame_length))
        else $error("verdict changed under stall");

    // rejected frames carry no header detail
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 4'(eip_pkg::ST_UDP_OK) |->
            o_source_address == 32'd0 && o_destination_address == 32'd0 &&
            o_source_port == 16'd0 && o_destination_port == 16'd0 &&
            o_payload_offset == 7'd0 && o_payload_length == 16'd0)
        else $error("detail on rejected frame");

    // drop flag goes with fragment verdict only
    a_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fragment_drop == (o_status == 4'(eip_pkg::ST_FRAGMENT)))
        else $error("fragment flag mismatch");

    // accepted payload lies inside the frame
    a_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == 4'(eip_pkg::ST_UDP_OK) |->
            o_payload_offset >= 7'd42 && o_payload_offset <= 7'd82 &&
            {1'b0, o_frame_length} >= {10'd0, o_payload_offset} + {1'b0, o_payload_length})
        else $error("payload beyond frame");

endmodule

bind eth_ipv4_udp_header_parser eip_checker u_eip_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_valid               (o_valid),
    .i_stall               (i_stall),
    .o_status              (o_status),
    .o_frame_length        (o_frame_length),
    .o_source_address      (o_source_address),
    .o_destination_address (o_destination_address),
    .o_source_port         (o_source_port),
    .o_destination_port    (o_destination_port),
    .o_payload_offset      (o_payload_offset),
    .o_payload_length      (o_payload_length),
    .o_fragment_drop       (o_fragment_drop)
);

[tb/testbench.sv]
// Testbench for the Ethernet/IPv4/UDP header parser.
//
// Frames are fed one byte word at a time over the valid/stall input channel.
// Every accepted byte also goes through a local copy of the header parser
// (byte counter plus capture registers). On the last byte of a frame that
// copy works out the verdict word, which is queued. The checker compares each
// verdict word leaving the block field by field against the oldest queued
// entry.
//
// The run covers these parts in turn:
//   - accepted UDP frames (minimum and maximum IHL, DF and reserved flag bits)
//   - short frames, EtherType handling, IP header checks, fragments, UDP checks
//   - random traffic: mostly well-formed UDP frames with random content, the
//     rest broken on purpose or plain noise
//
// Both sides insert random idle cycles, with bursts of back-to-back traffic
// in between.
module testbench;
    import eip_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_FRAMES = 8;
    localparam int MAX_WAIT      = 17;
    localparam int DRAIN_CYCLES  = 16;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [7:0]  i_frame_byte = '0;
    logic        i_last_byte  = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [3:0]  o_status;
    logic [15:0] o_frame_length;
    logic [31:0] o_source_address;
    logic [31:0] o_destination_address;
    logic [15:0] o_source_port;
    logic [15:0] o_destination_port;
    logic [6:0]  o_payload_offset;
    logic [15:0] o_payload_length;
    logic        o_fragment_drop;

    eth_ipv4_udp_header_parser dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_frame_byte          (i_frame_byte),
        .i_last_byte           (i_last_byte),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_status              (o_status),
        .o_frame_length        (o_frame_length),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_source_port         (o_source_port),
        .o_destination_port    (o_destination_port),
        .o_payload_offset      (o_payload_offset),
        .o_payload_length      (o_payload_length),
        .o_fragment_drop       (o_fragment_drop)
    );

    // Local copy of the parser state
    logic [15:0] byte_count     = '0;
    logic [15:0] cap_etype      = '0;
    logic [7:0]  cap_ver_ihl    = '0;
    logic [15:0] cap_total_len  = '0;
    logic [15:0] cap_flags_frag = '0;
    logic [7:0]  cap_protocol   = '0;
    logic [31:0] cap_src_addr   = '0;
    logic [31:0] cap_dst_addr   = '0;
    logic [31:0] cap_ports      = '0;
    logic [15:0] cap_udp_len    = '0;

    t_result    verdict_q[$];     // verdict words still owed by the block
    logic [7:0] frame_buf[$];     // frame under construction
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         calm_tx     = 0;  // remaining back-to-back words, input side
    int         calm_rx     = 0;  // same for the output side

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle cycles ahead of one word: 0..MAX_WAIT, now and then a burst of zeros.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Verdict for the frame that just ended; the checks run in priority order.
    function automatic t_status frame_status();
        int len;
        int hdr_len;
        int total;
        len     = int'(byte_count);
        hdr_len = 4 * cap_ver_ihl[3:0];
        total   = int'(cap_total_len);
        if (len < ETH_HDR_LEN) return ST_SHORT;
        if (cap_etype == ETHERTYPE_ARP) return ST_ARP;
        if (cap_etype != ETHERTYPE_IPV4) return ST_NOT_IPV4;
        if (len < ETH_HDR_LEN + MIN_IP_HDR_LEN) return ST_SHORT;
        if (cap_ver_ihl[7:4] != IP_VERSION || cap_ver_ihl[3:0] < MIN_IHL ||
            len < ETH_HDR_LEN + hdr_len) return ST_BAD_IHL;
        if (total < hdr_len || len < ETH_HDR_LEN + total) return ST_BAD_TOTAL;
        if ((cap_flags_frag & FRAG_MASK) != 0) return ST_FRAGMENT;
        if (cap_protocol != PROTO_UDP) return ST_NOT_UDP;
        // IP payload too small for a UDP header, or UDP length out of range
        if (total - hdr_len < UDP_HDR_LEN || cap_udp_len < UDP_HDR_LEN ||
            total - hdr_len < cap_udp_len) return ST_BAD_UDP_LEN;
        return ST_UDP_OK;
    endfunction

    // Capture one accepted byte; queue the verdict word on the last byte.
    task automatic predict_byte(input logic [7:0] value, input logic last);
        int      pos;
        int      udp_base;
        int      ofs;
        t_result res;
        pos = int'(byte_count);
        // UDP header follows the IP header, so its position moves with IHL
        udp_base = ETH_HDR_LEN + 4 * cap_ver_ihl[3:0];
        if (pos == 12 || pos == 13) cap_etype = {cap_etype[7:0], value};
        if (pos == 14) cap_ver_ihl = value;
        if (pos == 16 || pos == 17) cap_total_len = {cap_total_len[7:0], value};
        if (pos == 20 || pos == 21) cap_flags_frag = {cap_flags_frag[7:0], value};
        if (pos == 23) cap_protocol = value;
        if (pos >= 26 && pos <= 29) cap_src_addr = {cap_src_addr[23:0], value};
        if (pos >= 30 && pos <= 33) cap_dst_addr = {cap_dst_addr[23:0], value};
        if (pos > 14) begin
            if (pos >= udp_base && pos <= udp_base + 3)
                cap_ports = {cap_ports[23:0], value};
            if (pos == udp_base + 4 || pos == udp_base + 5)
                cap_udp_len = {cap_udp_len[7:0], value};
        end
        if (byte_count != COUNT_MAX) byte_count++;

        if (last) begin
            res = '0;
            res.status = frame_status();
            res.frame_length = byte_count;
            if (res.status == ST_UDP_OK) begin
                ofs = ETH_HDR_LEN + 4 * cap_ver_ihl[3:0] + UDP_HDR_LEN;
                res.src_addr       = cap_src_addr;
                res.dst_addr       = cap_dst_addr;
                res.udp_sport      = cap_ports[31:16];
                res.udp_dport      = cap_ports[15:0];
                res.payload_offset = ofs[6:0];
                res.payload_length = cap_udp_len - UDP_HDR_LEN;
            end
            res.fragment_drop = (res.status == ST_FRAGMENT);
            verdict_q.insert(verdict_q.size(), res);
            byte_count = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One byte word; valid stays up across back-to-back words.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = draw_wait(calm_tx);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= value;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(value, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Writes past the end of a short frame are dropped.
    task automatic put_byte(input int pos, input logic [7:0] value);
        if (pos < frame_buf.size()) frame_buf[pos] = value;
    endtask

    task automatic put_word(input int pos, input logic [15:0] value);
        put_byte(pos, value[15:8]);
        put_byte(pos + 1, value[7:0]);
    endtask

    task automatic cut_frame(input int len);
        while (frame_buf.size() > len) void'(frame_buf.pop_back());
    endtask

    // Random bytes with the header fields laid over them.
    task automatic build_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                               input int total, input logic [15:0] frag,
                               input logic [7:0] proto, input int ulen,
                               input int len);
        int base;
        base = ETH_HDR_LEN + 4 * ver_ihl[3:0];
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
        // UDP length first: with a tiny IHL it may overlap IP fields, which win
        put_word(base + 4, 16'(ulen));
        put_word(12, etype);
        put_byte(14, ver_ihl);
        put_word(16, 16'(total));
        put_word(20, frag);
        put_byte(23, proto);
    endtask

    // Well-formed UDP frame; spare = IP bytes past UDP, pad = Ethernet padding.
    task automatic good_frame(input int ihl, input int ulen, input int spare,
                              input int pad);
        logic [3:0] ihl4;
        int         total;
        ihl4  = 4'(ihl);
        total = 4 * ihl + ulen + spare;
        build_frame(ETHERTYPE_IPV4, {IP_VERSION, ihl4}, total, 16'h0000, PROTO_UDP,
                    ulen, ETH_HDR_LEN + total + pad);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Stall drawn once per verdict word, then held low until one is taken.
    initial begin : drive_output_stall
        int hold;
        forever begin
            hold = draw_wait(calm_rx);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_verdicts
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                $error("verdict word with none expected (status %0d)", o_status);
            end else begin
                want = verdict_q.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("frame_length", 32'(want.frame_length), 32'(o_frame_length));
                check_field("source_address", want.src_addr, o_source_address);
                check_field("destination_address", want.dst_addr, o_destination_address);
                check_field("source_port", 32'(want.udp_sport), 32'(o_source_port));
                check_field("destination_port", 32'(want.udp_dport),
                            32'(o_destination_port));
                check_field("payload_offset", 32'(want.payload_offset),
                            32'(o_payload_offset));
                check_field("payload_length", 32'(want.payload_length),
                            32'(o_payload_length));
                check_field("fragment_drop", 32'(want.fragment_drop),
                            32'(o_fragment_drop));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL eth_ipv4_udp_header_parser");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_udp_accept();
        good_frame(5, 8, 0, 0);       // empty payload, frame ends on UDP header
        send_frame();
        good_frame(15, 40, 0, 3);     // largest IHL: payload offset 82
        send_frame();
        good_frame(5, 20, 6, 0);
        put_byte(20, 8'h40);          // DF alone is not a fragment
        send_frame();
        good_frame(6, 12, 0, 10);
        put_byte(20, 8'h80);          // reserved bit is outside the mask
        send_frame();
    endtask

    task automatic test_short_frames();
        build_frame(ETHERTYPE_IPV4, 8'h45, 28, 16'h0000, PROTO_UDP, 8, 1);
        send_frame();                 // single-byte frame
        build_frame(ETHERTYPE_IPV4, 8'h45, 28, 16'h0000, PROTO_UDP, 8, 13);
        send_frame();
        good_frame(5, 8, 0, 0);
        cut_frame(33);                // IPv4 but header incomplete
        send_frame();
    endtask

    task automatic test_ethertypes();
        build_frame(ETHERTYPE_ARP, 8'h45, 28, 16'h0000, PROTO_UDP, 8, 14);
        send_frame();                 // bare Ethernet header, ARP
        good_frame(5, 8, 0, 0);
        put_word(12, ETHERTYPE_ARP);
        send_frame();
        good_frame(5, 8, 0, 0);
        put_word(12, 16'hFFFF);
        send_frame();
        good_frame(5, 8, 0, 0);
        put_word(12, 16'h0000);
        send_frame();
    endtask

    task automatic test_ip_header_checks();
        good_frame(5, 8, 0, 0);
        put_byte(14, 8'h65);          // IPv6 version nibble
        send_frame();
        good_frame(5, 16, 0, 0);
        put_byte(14, 8'h44);          // IHL below 5; UDP capture shifts too
        send_frame();
        good_frame(5, 16, 0, 0);
        put_byte(14, 8'h40);
        send_frame();
        good_frame(15, 8, 0, 0);
        cut_frame(73);                // frame ends inside the IP options
        send_frame();
        good_frame(6, 8, 0, 4);
        put_word(16, 16'd23);         // total length below header length
        send_frame();
        good_frame(5, 16, 0, 0);
        cut_frame(49);                // one byte short of the total length
        send_frame();
    endtask

    task automatic test_fragments();
        good_frame(5, 8, 4, 0);
        put_byte(20, 8'h20);          // more-fragments
        send_frame();
        good_frame(5, 8, 4, 0);
        put_word(20, 16'h1FFF);       // largest offset
        send_frame();
        good_frame(7, 10, 0, 2);
        put_word(20, 16'h4001);       // DF with offset
        send_frame();
    endtask

    task automatic test_udp_checks();
        good_frame(5, 8, 0, 0);
        put_byte(23, 8'd6);           // TCP
        send_frame();
        build_frame(ETHERTYPE_IPV4, 8'h45, 27, 16'h0000, PROTO_UDP, 8, 46);
        send_frame();                 // IP payload too small for UDP header
        good_frame(5, 8, 4, 0);
        put_word(38, 16'd7);
        send_frame();
        good_frame(5, 8, 4, 0);
        put_word(38, 16'd0);
        send_frame();
        good_frame(5, 16, 0, 2);
        put_word(38, 16'd17);         // UDP length past the IP payload
        send_frame();
    endtask

    task automatic test_random_frames();
        int          ihl;
        int          ulen;
        int          total;
        int          len;
        int          kind;
        logic [3:0]  ihl4;
        logic [1:0]  top_flags;
        logic [15:0] etype;
        logic [15:0] frag;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        repeat (RANDOM_FRAMES) begin
            ihl        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            ihl4       = 4'(ihl);
            ulen       = UDP_HDR_LEN + $urandom_range(0, 24);
            total      = 4 * ihl + ulen + $urandom_range(0, 3);
            len        = ETH_HDR_LEN + total + $urandom_range(0, 6);
            top_flags  = 2'($urandom_range(0, 3));
            etype      = ETHERTYPE_IPV4;
            ver_ihl    = {IP_VERSION, ihl4};
            frag       = {top_flags, 14'd0};
            proto      = PROTO_UDP;
            kind       = $urandom_range(0, 21);
            case (kind)
                12: len = $urandom_range(1, 33);
                13: etype = $urandom_range(0, 1) ? ETHERTYPE_ARP
                            : 16'($urandom_range(0, 65535));
                14: ver_ihl = 8'($urandom_range(0, 255));
                15: len = $urandom_range(ETH_HDR_LEN, ETH_HDR_LEN + total - 1);
                16: total = $urandom_range(0, 4 * ihl - 1);
                17: frag[13:0] = 14'($urandom_range(1, 16'h3FFF));
                18: proto = 8'($urandom_range(0, 255));
                19: ulen = $urandom_range(0, 1) ? $urandom_range(0, 7)
                           : total - 4 * ihl + $urandom_range(1, 20);
                20, 21: begin
                    // noise, half of it still tagged as IPv4
                    etype      = $urandom_range(0, 1) ? ETHERTYPE_IPV4
                                 : 16'($urandom_range(0, 65535));
                    ver_ihl    = 8'($urandom_range(0, 255));
                    total      = $urandom_range(0, 65535);
                    frag       = 16'($urandom_range(0, 65535));
                    proto      = 8'($urandom_range(0, 255));
                    ulen       = $urandom_range(0, 65535);
                    len        = $urandom_range(1, 100);
                end
                default: ;
            endcase
            build_frame(etype, ver_ihl, total, frag, proto, ulen, len);
            send_frame();
        end
    endtask

    initial begin : run_tests
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_udp_accept();
        test_short_frames();
        test_ethertypes();
        test_ip_header_checks();
        test_fragments();
        test_udp_checks();
        test_random_frames();

        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        // catch any stray word after the last verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS eth_ipv4_udp_header_parser");
        else
            $display("FAIL eth_ipv4_udp_header_parser");
        $finish;
    end
endmodule

[files.f]
design/eip_pkg.sv
design/eip_capture.sv
design/eip_verdict.sv
design/eth_ipv4_udp_header_parser.sv
design/eip_checker.sv
tb/testbench.sv
